>>> hw/rtl/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared constants for the link path health monitor: widths, the loss
// rate scale, register reset values and configuration register indexes.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int COUNTER_WIDTH   = 32;
  localparam int LATENCY_WIDTH   = 32;
  localparam int FIELD_WIDTH     = 32;
  localparam int RATE_WIDTH      = 15;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [RATE_WIDTH-1:0] RATE_SCALE    = 15'd25600;
  localparam logic [RATE_WIDTH-1:0] FAIL_RESET    = 15'd12800;
  localparam logic [RATE_WIDTH-1:0] DEGRADE_RESET = 15'd1280;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAIL_LOSS_LIMIT    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEGRADE_LOSS_LIMIT = 2'd1;

endpackage

>>> hw/rtl/link_path_health_monitor_core.sv
// ----------------------------------------------------------------------------
// link_path_health_monitor_core
// Per-interval link report in, cumulative loss rate, latency average,
// peak, jitter, error total and link health out.
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid / item_stall) takes one interval report a beat:
//   sent, received and error counts and a latency sample (zero = none).
//   result channel (result_valid / result_stall) returns one beat per report.
//   cfg channel (cfg_valid / cfg_ready, always ready) writes the fail and
//   degrade loss limits; write only while no report is in flight.
// processing:
//   an accepted report passes through the totals, the divider set-up,
//   18 steps of the shared loss-rate subtract unit (one per rate bit plus
//   one per set bit of 25600) once packets have been sent, the start of the
//   averages, for a latency sample two passes of the decimal digit unit
//   (each only on a nonzero average) with a step between them, and the load
//   of the result. item_stall stays high while a report is worked, so the
//   next report is taken only once the last has been loaded for output.
// reset:
//   rst clears all totals, averages and the peak, loads the limit defaults
//   and empties the result register.
// stall:
//   the result sits in its register under result_stall; the next report is
//   accepted and worked meanwhile and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module link_path_health_monitor_core #(
  parameter int COUNTER_WIDTH = lphm_pkg::COUNTER_WIDTH,
  parameter int LATENCY_WIDTH = lphm_pkg::LATENCY_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]      sent_count,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]      received_count,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]      error_count,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]      latency_sample,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [lphm_pkg::RATE_WIDTH-1:0]       loss_rate,
  output logic [lphm_pkg::FIELD_WIDTH-1:0]      mean_latency,
  output logic [lphm_pkg::FIELD_WIDTH-1:0]      peak_latency,
  output logic [lphm_pkg::FIELD_WIDTH-1:0]      jitter_level,
  output logic [lphm_pkg::FIELD_WIDTH-1:0]      error_total,
  output logic                                  link_up,
  output logic                                  link_degraded,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lphm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [lphm_pkg::RATE_WIDTH-1:0]       cfg_data
);

  localparam int CW  = COUNTER_WIDTH;
  localparam int LW  = LATENCY_WIDTH;
  localparam int FW  = lphm_pkg::FIELD_WIDTH;
  localparam int RW  = lphm_pkg::RATE_WIDTH;
  localparam int CXW = (CW > FW) ? CW : FW;
  localparam int LXW = (LW > FW) ? LW : FW;
  localparam int SW  = ((LW + 4 + 3) / 4) * 4;
  localparam int NIB_COUNT = SW / 4;
  localparam int NIB_W = (NIB_COUNT > 1) ? $clog2(NIB_COUNT) : 1;
  localparam int BIT_W = $clog2(RW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOTAL,
    S_DIV_INIT,
    S_DIV,
    S_LAT,
    S_EMA_AVG,
    S_DEV,
    S_EMA_JIT,
    S_DONE
  } state_t;

  state_t state;

  logic [RW-1:0] fail_loss_limit;
  logic [RW-1:0] degrade_loss_limit;

  logic [CW-1:0] sent_total;
  logic [CW-1:0] received_total;
  logic [CW-1:0] lost_total;
  logic [CW-1:0] errors_total;
  logic [RW-1:0] held_loss_rate;
  logic [LW-1:0] average_latency;
  logic [LW-1:0] largest_latency;
  logic [LW-1:0] jitter_average;

  // latched report
  logic [CW-1:0] item_sent;
  logic [CW-1:0] item_recv;
  logic [CW-1:0] item_errs;
  logic [CW-1:0] item_lost;
  logic [LW-1:0] item_lat;

  // loss-rate unit
  logic [CW-1:0]    rem;
  logic [CW-1:0]    dv_a;
  logic [RW-1:0]    quo;
  logic [BIT_W-1:0] bit_idx;
  logic             dv_phase;

  // decimal digit unit
  logic [SW-1:0]    em_num;
  logic [SW-1:0]    em_quo;
  logic [3:0]       em_r;
  logic [NIB_W-1:0] em_cnt;

  function automatic logic [CW-1:0] clip_cnt(input logic [FW-1:0] v);
    logic [CXW-1:0] e;
    e = CXW'(v);
    clip_cnt = (e > CXW'({CW{1'b1}})) ? {CW{1'b1}} : e[CW-1:0];
  endfunction

  function automatic logic [LW-1:0] clip_lat(input logic [FW-1:0] v);
    logic [LXW-1:0] e;
    e = LXW'(v);
    clip_lat = (e > LXW'({LW{1'b1}})) ? {LW{1'b1}} : e[LW-1:0];
  endfunction

  function automatic logic [FW-1:0] cnt_out(input logic [CW-1:0] v);
    logic [CXW-1:0] e;
    e = CXW'(v);
    cnt_out = (e > CXW'({FW{1'b1}})) ? {FW{1'b1}} : e[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] lat_out(input logic [LW-1:0] v);
    logic [LXW-1:0] e;
    e = LXW'(v);
    lat_out = (e > LXW'({FW{1'b1}})) ? {FW{1'b1}} : e[FW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [3:0] tenth_digit(input logic [7:0] t);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (t >= 8'(10 * k)) d = 4'(k);
    end
    tenth_digit = d;
  endfunction

  function automatic logic [SW-1:0] ema_sum(input logic [LW-1:0] old, input logic [LW-1:0] x);
    ema_sum = (SW'(old) << 3) + SW'(old) + SW'(x);
  endfunction

  // loss-rate step
  logic [CW-1:0] dv_y;
  logic [CW-1:0] dv_d;
  logic          dv_hit;
  logic [CW-1:0] rem_next;
  logic [RW-1:0] dv_qbase;
  logic [RW-1:0] quo_next;
  logic [RW-1:0] rate_clip;

  always_comb begin
    dv_y      = dv_phase ? dv_a : rem;
    dv_d      = sent_total - dv_y;
    dv_hit    = (rem >= dv_d);
    rem_next  = dv_hit ? (rem - dv_d) : (rem + dv_y);
    dv_qbase  = dv_phase ? quo : {quo[RW-2:0], 1'b0};
    quo_next  = dv_qbase + RW'(dv_hit);
    rate_clip = (quo_next > lphm_pkg::RATE_SCALE) ? lphm_pkg::RATE_SCALE : quo_next;
  end

  // digit step
  logic [7:0]    em_t;
  logic [3:0]    em_digit;
  logic [7:0]    em_prod;
  logic [7:0]    em_diff;
  logic [SW-1:0] em_quo_next;

  always_comb begin
    em_t        = {em_r, em_num[SW-1 -: 4]};
    em_digit    = tenth_digit(em_t);
    em_prod     = (8'(em_digit) << 3) + (8'(em_digit) << 1);
    em_diff     = em_t - em_prod;
    em_quo_next = {em_quo[SW-5:0], em_digit};
  end

  logic [FW-1:0] lost_in;
  logic [LW-1:0] dev;
  logic          out_free;

  always_comb begin
    lost_in  = (received_count > sent_count) ? '0 : (sent_count - received_count);
    dev      = (item_lat > average_latency) ? (item_lat - average_latency)
                                            : (average_latency - item_lat);
    out_free = !result_valid || !result_stall;
  end

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      result_valid       <= 1'b0;
      fail_loss_limit    <= lphm_pkg::FAIL_RESET;
      degrade_loss_limit <= lphm_pkg::DEGRADE_RESET;
      sent_total         <= '0;
      received_total     <= '0;
      lost_total         <= '0;
      errors_total       <= '0;
      held_loss_rate     <= '0;
      average_latency    <= '0;
      largest_latency    <= '0;
      jitter_average     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lphm_pkg::REG_FAIL_LOSS_LIMIT:    fail_loss_limit    <= cfg_data;
          lphm_pkg::REG_DEGRADE_LOSS_LIMIT: degrade_loss_limit <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_DONE && out_free) result_valid <= 1'b1;
      else if (!result_stall)          result_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_sent <= clip_cnt(sent_count);
            item_recv <= clip_cnt(received_count);
            item_errs <= clip_cnt(error_count);
            item_lost <= clip_cnt(lost_in);
            item_lat  <= clip_lat(latency_sample);
            state     <= S_TOTAL;
          end
        end
        S_TOTAL: begin
          sent_total     <= sat_add(sent_total, item_sent);
          received_total <= sat_add(received_total, item_recv);
          lost_total     <= sat_add(lost_total, item_lost);
          errors_total   <= sat_add(errors_total, item_errs);
          state          <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          if (sent_total != '0) begin
            dv_a     <= (lost_total > sent_total) ? sent_total : lost_total;
            rem      <= '0;
            quo      <= '0;
            bit_idx  <= BIT_W'(RW - 1);
            dv_phase <= 1'b0;
            state    <= S_DIV;
          end else begin
            state <= S_LAT;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          if (!dv_phase && lphm_pkg::RATE_SCALE[bit_idx]) begin
            dv_phase <= 1'b1;
          end else if (bit_idx == '0) begin
            held_loss_rate <= rate_clip;
            state          <= S_LAT;
          end else begin
            bit_idx  <= bit_idx - 1'b1;
            dv_phase <= 1'b0;
          end
        end
        S_LAT: begin
          if (item_lat == '0) begin
            state <= S_DONE;
          end else begin
            if (item_lat > largest_latency) largest_latency <= item_lat;
            if (average_latency == '0) begin
              average_latency <= item_lat;
              state           <= S_DEV;
            end else begin
              em_num <= ema_sum(average_latency, item_lat);
              em_quo <= '0;
              em_r   <= '0;
              em_cnt <= NIB_W'(NIB_COUNT - 1);
              state  <= S_EMA_AVG;
            end
          end
        end
        S_EMA_AVG: begin
          em_num <= em_num << 4;
          em_quo <= em_quo_next;
          em_r   <= em_diff[3:0];
          em_cnt <= em_cnt - 1'b1;
          if (em_cnt == '0) begin
            average_latency <= em_quo_next[LW-1:0];
            state           <= S_DEV;
          end
        end
        S_DEV: begin
          if (jitter_average == '0) begin
            jitter_average <= dev;
            state          <= S_DONE;
          end else begin
            em_num <= ema_sum(jitter_average, dev);
            em_quo <= '0;
            em_r   <= '0;
            em_cnt <= NIB_W'(NIB_COUNT - 1);
            state  <= S_EMA_JIT;
          end
        end
        S_EMA_JIT: begin
          em_num <= em_num << 4;
          em_quo <= em_quo_next;
          em_r   <= em_diff[3:0];
          em_cnt <= em_cnt - 1'b1;
          if (em_cnt == '0) begin
            jitter_average <= em_quo_next[LW-1:0];
            state          <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            loss_rate     <= held_loss_rate;
            mean_latency  <= lat_out(average_latency);
            peak_latency  <= lat_out(largest_latency);
            jitter_level  <= lat_out(jitter_average);
            error_total   <= cnt_out(errors_total);
            link_up       <= !(held_loss_rate > fail_loss_limit);
            link_degraded <= (held_loss_rate > fail_loss_limit)
                          || (held_loss_rate > degrade_loss_limit);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/link_health_checker.sv
// ----------------------------------------------------------------------------
// link_health_checker
// Watches the report, result and limit channels of the link path health
// monitor. For every accepted report it works out the expected loss rate,
// latency average, peak, jitter, error total and health flags from its own
// copy of the totals and limits, then compares each result beat against the
// oldest expected one and counts every fault it finds.
// ----------------------------------------------------------------------------
module link_health_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic                                 item_stall,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     sent_count,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     received_count,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     error_count,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     latency_sample,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic [lphm_pkg::RATE_WIDTH-1:0]      loss_rate,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     mean_latency,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     peak_latency,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     jitter_level,
  input  logic [lphm_pkg::FIELD_WIDTH-1:0]     error_total,
  input  logic                                 link_up,
  input  logic                                 link_degraded,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [lphm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lphm_pkg::RATE_WIDTH-1:0]      cfg_data,
  input  logic                                 run_done,
  output int                                   fault_count,
  output int                                   reports_due,
  output int                                   reports_seen,
  output int                                   down_seen,
  output int                                   degraded_seen,
  output logic [lphm_pkg::RATE_WIDTH-1:0]      rate_now
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNTER_WIDTH = lphm_pkg::COUNTER_WIDTH;
  localparam int LATENCY_WIDTH = lphm_pkg::LATENCY_WIDTH;
  localparam int FIELD_WIDTH   = lphm_pkg::FIELD_WIDTH;
  localparam int RATE_WIDTH    = lphm_pkg::RATE_WIDTH;

  typedef struct packed {
    logic [RATE_WIDTH-1:0]  rate;
    logic [FIELD_WIDTH-1:0] mean;
    logic [FIELD_WIDTH-1:0] peak;
    logic [FIELD_WIDTH-1:0] jitter;
    logic [FIELD_WIDTH-1:0] errors;
    logic                   up;
    logic                   degraded;
  } health_t;

  logic [COUNTER_WIDTH-1:0] sent_sum;
  logic [COUNTER_WIDTH-1:0] recv_sum;
  logic [COUNTER_WIDTH-1:0] lost_sum;
  logic [COUNTER_WIDTH-1:0] err_sum;
  logic [LATENCY_WIDTH-1:0] lat_avg;
  logic [LATENCY_WIDTH-1:0] lat_peak;
  logic [LATENCY_WIDTH-1:0] jit_avg;
  logic [RATE_WIDTH-1:0]    down_limit;
  logic [RATE_WIDTH-1:0]    degrade_limit;
  health_t                  health_due[$];
  bit                       closed;

  function automatic logic [COUNTER_WIDTH-1:0] sat_sum(input logic [COUNTER_WIDTH-1:0] a,
                                                       input logic [FIELD_WIDTH-1:0] b);
    logic [COUNTER_WIDTH:0] s;
    s = {1'b0, a} + (COUNTER_WIDTH+1)'(b);
    return s[COUNTER_WIDTH] ? '1 : s[COUNTER_WIDTH-1:0];
  endfunction

  // floor((9*old + x) / 10), wide enough not to overflow
  function automatic logic [LATENCY_WIDTH-1:0] tenth_blend(input logic [LATENCY_WIDTH-1:0] old,
                                                           input logic [LATENCY_WIDTH-1:0] x);
    logic [LATENCY_WIDTH+3:0] s;
    s = (LATENCY_WIDTH+4)'(old) * 9 + (LATENCY_WIDTH+4)'(x);
    return LATENCY_WIDTH'(s / 10);
  endfunction

  function automatic health_t advance_link_stats(input logic [FIELD_WIDTH-1:0] sent,
                                                 input logic [FIELD_WIDTH-1:0] recv,
                                                 input logic [FIELD_WIDTH-1:0] errs,
                                                 input logic [FIELD_WIDTH-1:0] lat);
    health_t                             h;
    logic [FIELD_WIDTH-1:0]              lost;
    logic [COUNTER_WIDTH-1:0]            lost_clip;
    logic [COUNTER_WIDTH+RATE_WIDTH-1:0] scaled;
    logic [LATENCY_WIDTH-1:0]            dev;
    lost     = (recv > sent) ? '0 : sent - recv;
    sent_sum = sat_sum(sent_sum, sent);
    recv_sum = sat_sum(recv_sum, recv);
    lost_sum = sat_sum(lost_sum, lost);
    err_sum  = sat_sum(err_sum, errs);
    // rate holds while nothing has been sent
    if (sent_sum != '0) begin
      lost_clip = (lost_sum > sent_sum) ? sent_sum : lost_sum;
      scaled    = (COUNTER_WIDTH+RATE_WIDTH)'(lost_clip) * lphm_pkg::RATE_SCALE;
      scaled    = scaled / sent_sum;
      rate_now  = (scaled > lphm_pkg::RATE_SCALE) ? lphm_pkg::RATE_SCALE
                                                  : RATE_WIDTH'(scaled);
    end
    if (lat != '0) begin
      lat_avg = (lat_avg == '0) ? lat : tenth_blend(lat_avg, lat);
      if (lat > lat_peak) begin
        lat_peak = lat;
      end
      dev     = (lat > lat_avg) ? lat - lat_avg : lat_avg - lat;
      jit_avg = (jit_avg == '0) ? dev : tenth_blend(jit_avg, dev);
    end
    h.rate     = rate_now;
    h.mean     = lat_avg;
    h.peak     = lat_peak;
    h.jitter   = jit_avg;
    h.errors   = err_sum;
    h.up       = !(rate_now > down_limit);
    h.degraded = (rate_now > down_limit) || (rate_now > degrade_limit);
    return h;
  endfunction

  task automatic report_fault(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fault_count++;
  endtask

  task automatic compare_field(input string name, input logic [FIELD_WIDTH-1:0] got,
                               input logic [FIELD_WIDTH-1:0] want);
    if (got !== want) begin
      report_fault($sformatf("report %0d %s got %0d want %0d", reports_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    health_t want;
    if (rst) begin
      sent_sum      = '0;
      recv_sum      = '0;
      lost_sum      = '0;
      err_sum       = '0;
      lat_avg       = '0;
      lat_peak      = '0;
      jit_avg       = '0;
      rate_now      = '0;
      down_limit    = lphm_pkg::FAIL_RESET;
      degrade_limit = lphm_pkg::DEGRADE_RESET;
      health_due.delete();
      closed        = 1'b0;
      fault_count   = 0;
      reports_due   = 0;
      reports_seen  = 0;
      down_seen     = 0;
      degraded_seen = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (health_due.size() == 0) begin
          report_fault("result beat with no report outstanding");
        end else begin
          want = health_due.pop_front();
          compare_field("loss_rate", FIELD_WIDTH'(loss_rate), FIELD_WIDTH'(want.rate));
          compare_field("mean_latency", mean_latency, want.mean);
          compare_field("peak_latency", peak_latency, want.peak);
          compare_field("jitter_level", jitter_level, want.jitter);
          compare_field("error_total", error_total, want.errors);
          compare_field("link_up", FIELD_WIDTH'(link_up), FIELD_WIDTH'(want.up));
          compare_field("link_degraded", FIELD_WIDTH'(link_degraded),
                        FIELD_WIDTH'(want.degraded));
          reports_seen++;
          if (!want.up) begin
            down_seen++;
          end
          if (want.degraded) begin
            degraded_seen++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        health_due.push_back(advance_link_stats(sent_count, received_count, error_count,
                                                latency_sample));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lphm_pkg::REG_FAIL_LOSS_LIMIT: begin
            down_limit = cfg_data;
          end
          lphm_pkg::REG_DEGRADE_LOSS_LIMIT: begin
            degrade_limit = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (run_done && !closed) begin
        closed = 1'b1;
        while (health_due.size() != 0) begin
          want = health_due.pop_front();
          report_fault($sformatf("expected result never came, loss rate %0d", want.rate));
        end
      end
      reports_due = health_due.size();
    end
  end

endmodule

>>> dv/link_path_health_monitor_core_test.sv
// ----------------------------------------------------------------------------
// link_path_health_monitor_core_test
// Drives interval reports into the link path health monitor under random
// gaps and back-pressure, reprograms the fail and degrade loss limits
// between phases, and leaves all checking to link_health_checker. A short
// directed opening and a saturating close frame several random phases with
// their own loss profile, latency spread and limits.
// ----------------------------------------------------------------------------
module link_path_health_monitor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_WIDTH     = lphm_pkg::FIELD_WIDTH;
  localparam int RATE_WIDTH      = lphm_pkg::RATE_WIDTH;
  localparam int CFG_INDEX_WIDTH = lphm_pkg::CFG_INDEX_WIDTH;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 95;

  // indexes with no register behind them
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_B = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic [FIELD_WIDTH-1:0]     sent_count = '0;
  logic [FIELD_WIDTH-1:0]     received_count = '0;
  logic [FIELD_WIDTH-1:0]     error_count = '0;
  logic [FIELD_WIDTH-1:0]     latency_sample = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [RATE_WIDTH-1:0]      loss_rate;
  logic [FIELD_WIDTH-1:0]     mean_latency;
  logic [FIELD_WIDTH-1:0]     peak_latency;
  logic [FIELD_WIDTH-1:0]     jitter_level;
  logic [FIELD_WIDTH-1:0]     error_total;
  logic                       link_up;
  logic                       link_degraded;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [RATE_WIDTH-1:0]      cfg_data = '0;
  logic                       run_done = 1'b0;

  int                         fault_count;
  int                         reports_due;
  int                         reports_seen;
  int                         down_seen;
  int                         degraded_seen;
  logic [RATE_WIDTH-1:0]      rate_now;

  bit                         idle_on = 1'b0;
  bit                         hold_req = 1'b0;
  int                         settings = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_path_health_monitor_core dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .sent_count     (sent_count),
    .received_count (received_count),
    .error_count    (error_count),
    .latency_sample (latency_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .loss_rate      (loss_rate),
    .mean_latency   (mean_latency),
    .peak_latency   (peak_latency),
    .jitter_level   (jitter_level),
    .error_total    (error_total),
    .link_up        (link_up),
    .link_degraded  (link_degraded),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  link_health_checker chk (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .sent_count     (sent_count),
    .received_count (received_count),
    .error_count    (error_count),
    .latency_sample (latency_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .loss_rate      (loss_rate),
    .mean_latency   (mean_latency),
    .peak_latency   (peak_latency),
    .jitter_level   (jitter_level),
    .error_total    (error_total),
    .link_up        (link_up),
    .link_degraded  (link_degraded),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .run_done       (run_done),
    .fault_count    (fault_count),
    .reports_due    (reports_due),
    .reports_seen   (reports_seen),
    .down_seen      (down_seen),
    .degraded_seen  (degraded_seen),
    .rate_now       (rate_now)
  );

  task automatic send_report(input logic [FIELD_WIDTH-1:0] s, input logic [FIELD_WIDTH-1:0] r,
                             input logic [FIELD_WIDTH-1:0] e, input logic [FIELD_WIDTH-1:0] l);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    item_valid     <= 1'b1;
    sent_count     <= s;
    received_count <= r;
    error_count    <= e;
    latency_sample <= l;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // sender stops until every outstanding result beat has come back
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_limits(input logic [RATE_WIDTH-1:0] fail_v,
                                input logic [RATE_WIDTH-1:0] degrade_v,
                                input logic [RATE_WIDTH-1:0] spare_v);
    logic [CFG_INDEX_WIDTH-1:0] idx[4];
    logic [RATE_WIDTH-1:0]      val[4];
    idx = '{REG_UNMAPPED_A, lphm_pkg::REG_FAIL_LOSS_LIMIT, REG_UNMAPPED_B,
            lphm_pkg::REG_DEGRADE_LOSS_LIMIT};
    val = '{spare_v, fail_v, ~spare_v, degrade_v};
    foreach (idx[i]) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic random_report(input int drop_pct, input logic [FIELD_WIDTH-1:0] lat_base,
                               input int lat_spread);
    logic [FIELD_WIDTH-1:0] s;
    logic [FIELD_WIDTH-1:0] r;
    logic [FIELD_WIDTH-1:0] e;
    logic [FIELD_WIDTH-1:0] l;
    int                     pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      s = '0;
    end else if (pick == 1) begin
      s = $urandom_range(0, 65535);
    end else begin
      s = $urandom_range(0, 2000);
    end
    if ($urandom_range(0, 9) == 0) begin
      r = s + $urandom_range(1, 100);
    end else begin
      r = s - $urandom_range(0, (s * drop_pct) / 100);
    end
    e = ($urandom_range(0, 3) == 0) ? '0 : FIELD_WIDTH'($urandom_range(0, 50));
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      l = '0;
    end else if (pick == 3) begin
      l = $urandom;
    end else begin
      l = lat_base + $urandom_range(0, lat_spread);
    end
    send_report(s, r, e, l);
  endtask

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no beat on any channel for %0d cycles", IDLE_LIMIT);
    $display("link_path_health_monitor_core_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    int                     near;
    int                     drop_pct;
    int                     lat_spread;
    logic [FIELD_WIDTH-1:0] lat_base;
    logic [RATE_WIDTH-1:0]  fail_v;
    logic [RATE_WIDTH-1:0]  degrade_v;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    program_limits(lphm_pkg::FAIL_RESET, lphm_pkg::DEGRADE_RESET, '0);
    send_report('0, '0, '0, '0);
    send_report('0, 32'd7, 32'd1, '0);
    send_report(32'd1000, 32'd900, 32'd3, 32'd2560);
    send_report(32'd1000, 32'd1000, '0, 32'd5120);
    send_report(32'd200, 32'd350, 32'd5, 32'd1);
    send_report(32'd400, '0, '0, '0);
    send_report('0, '0, 32'd2, '1);
    send_report(32'd50, 32'd49, '0, 32'd3000);

    settle();
    program_limits('0, '0, '1);
    send_report(32'd10, 32'd9, '0, 32'd700);
    send_report(32'd10, 32'd10, '0, '0);

    settle();
    program_limits(lphm_pkg::RATE_SCALE, lphm_pkg::RATE_SCALE, '0);
    send_report(32'd10, '0, 32'd1, 32'd900);
    send_report(32'd10, 32'd10, '0, 32'd800);

    settle();
    program_limits('1, '1, '1);
    send_report(32'd20, 32'd5, '0, 32'd850);
    send_report(32'd20, 32'd20, 32'd4, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      idle_on = (phase != 3);
      near = int'(rate_now);
      case ($urandom_range(0, 3))
        0: begin
          fail_v    = RATE_WIDTH'((near + 50 > 25600) ? 25600 : near + $urandom_range(0, 50));
          degrade_v = RATE_WIDTH'((near > 100) ? near - $urandom_range(0, 100) : 0);
        end
        1: begin
          fail_v    = RATE_WIDTH'($urandom_range(0, 25600));
          degrade_v = RATE_WIDTH'($urandom_range(0, 25600));
        end
        2: begin
          fail_v    = lphm_pkg::RATE_SCALE;
          degrade_v = '0;
        end
        default: begin
          fail_v    = RATE_WIDTH'($urandom_range(0, 25600));
          degrade_v = RATE_WIDTH'($urandom_range(0, int'(fail_v)));
        end
      endcase
      program_limits(fail_v, degrade_v, RATE_WIDTH'($urandom));
      case ($urandom_range(0, 4))
        0: drop_pct = 0;
        1: drop_pct = 3;
        2: drop_pct = 25;
        3: drop_pct = 70;
        default: drop_pct = 100;
      endcase
      lat_base   = $urandom_range(256, 1 << 20);
      lat_spread = $urandom_range(0, 4096);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 1 && k == 20) begin
          hold_req = 1'b1;
        end
        random_report(drop_pct, lat_base, lat_spread);
      end
    end

    // totals run into saturation here, so this stretch comes last
    settle();
    idle_on = 1'b0;
    repeat (20) send_report($urandom, $urandom, $urandom, $urandom);
    send_report('1, '0, '1, 32'd1);
    send_report('1, '1, '1, '1);
    send_report('0, '0, '0, '0);
    settle();

    run_done <= 1'b1;
    repeat (2) @(negedge clk);
    $display("checked %0d reports across %0d limit settings, unmapped indexes included",
             reports_seen, settings);
    $display("link down on %0d reports, degraded on %0d", down_seen, degraded_seen);
    if (fault_count == 0) begin
      $display("link_path_health_monitor_core_test OK");
    end else begin
      $display("link_path_health_monitor_core_test NOT OK");
    end
    $finish;
  end

endmodule
